>>> rtl/xrs_pkg.sv
// Shared types and constants of the xoroshiro128** random stream block.
// Used by xrs_front, xrs_mul64, xrs_back and xoroshiro_random_stream.
// No dependencies.
package xrs_pkg;

	localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef enum logic [1:0] {
		CMD_SEED = 2'd0,
		CMD_INT  = 2'd1,
		CMD_FRAC = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	// One classified command as it waits between front and back.
	typedef struct packed {
		cmd_t        cmd;
		logic [63:0] seed;
		logic [31:0] idx1;
		logic [31:0] lo;
		logic [31:0] width;
	} xrs_item_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] product;
	} mul_rsp_t;

	typedef enum logic [1:0] {
		MP_IDLE,
		MP_LL,
		MP_LH,
		MP_HL
	} mul_phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WORD,
		ST_SCALE_GO,
		ST_SCALE,
		ST_SEED_IDX,
		ST_MIX0,
		ST_MIX_A,
		ST_MIX_B,
		ST_EMIT
	} back_state_t;

	function automatic logic [63:0] rotl64(input logic [63:0] v, input int n);
		rotl64 = (v << n) | (v >> (64 - n));
	endfunction

endpackage

>>> rtl/xrs_front.sv
// Front part: takes commands from the input queue port, orders the bounds,
// and holds classified items in a two-entry queue for the back part. Uses xrs_pkg.
module xrs_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            command,
	input  logic [63:0]           seed_value,
	input  logic [30:0]           stream_index,
	input  logic signed [31:0]    range_low,
	input  logic signed [31:0]    range_high,
	output xrs_pkg::xrs_item_t    item,
	output logic                  item_valid,
	input  logic                  take
);
	import xrs_pkg::*;

	xrs_item_t           q_mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	xrs_item_t           new_item;
	logic                wr_en;
	logic                rd_en;
	logic                swap;
	logic [31:0]         lo_sel;
	logic [31:0]         hi_sel;

	always_comb begin
		swap   = range_high < range_low;
		lo_sel = swap ? range_high : range_low;
		hi_sel = swap ? range_low : range_high;
		new_item.cmd   = cmd_t'(command);
		new_item.seed  = seed_value;
		new_item.idx1  = {1'b0, stream_index} + 32'd1;
		new_item.lo    = lo_sel;
		// A full 32-bit span wraps to zero width.
		new_item.width = hi_sel - lo_sel + 32'd1;
	end

	assign full       = count_q == QCNT_W'(QDEPTH);
	assign item_valid = count_q != '0;
	assign item       = q_mem_q[rd_ptr_q];
	assign wr_en      = push && !full;
	assign rd_en      = take && item_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("front queue count exceeds its depth");

	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> item_valid)
		else $error("back took an item from an empty front queue");

endmodule

>>> rtl/xrs_mul64.sv
// Iterative 64x64 multiplier giving the low 64 product bits with one shared
// 32x32 multiplier, stepping through MP_LL, MP_LH and MP_HL. Uses xrs_pkg.
module xrs_mul64 (
	input  logic                clk,
	input  logic                arst_n,
	input  xrs_pkg::mul_req_t   req,
	output xrs_pkg::mul_rsp_t   rsp
);
	import xrs_pkg::*;

	mul_phase_t   phase_q;
	mul_phase_t   phase_d;
	logic [63:0]  opa_q;
	logic [63:0]  opb_q;
	logic [63:0]  lo_q;
	logic [31:0]  mid_q;
	logic [63:0]  prod_q;
	logic         done_q;
	logic [31:0]  x_op;
	logic [31:0]  y_op;
	logic [63:0]  mul_full;

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			MP_IDLE: if (req.start) phase_d = MP_LL;
			MP_LL:   phase_d = MP_LH;
			MP_LH:   phase_d = MP_HL;
			MP_HL:   phase_d = MP_IDLE;
			default: phase_d = MP_IDLE;
		endcase
	end

	always_comb begin
		case (phase_q)
			MP_LL: begin
				x_op = opa_q[31:0];
				y_op = opb_q[31:0];
			end
			MP_LH: begin
				x_op = opa_q[31:0];
				y_op = opb_q[63:32];
			end
			default: begin
				x_op = opa_q[63:32];
				y_op = opb_q[31:0];
			end
		endcase
	end

	assign mul_full = x_op * y_op;

	always_ff @(posedge clk) begin
		if (phase_q == MP_IDLE && req.start) begin
			opa_q <= req.a;
			opb_q <= req.b;
		end
		if (phase_q == MP_LL) begin
			lo_q <= mul_full;
		end
		if (phase_q == MP_LH) begin
			mid_q <= lo_q[63:32] + mul_full[31:0];
		end
		if (phase_q == MP_HL) begin
			prod_q <= {mid_q + mul_full[31:0], lo_q[31:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MP_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= phase_q == MP_HL;
		end
	end

	assign rsp.done    = done_q;
	assign rsp.product = prod_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> phase_q == MP_IDLE)
		else $error("multiply started while the unit was busy");

endmodule

>>> rtl/xrs_back.sv
// Back part: holds the generator state, runs seed, draw and unused commands with a
// sequencer around the shared multiplier, and keeps the result register. Uses xrs_pkg.
module xrs_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  xrs_pkg::xrs_item_t    item,
	input  logic                  item_valid,
	output logic                  take,
	output xrs_pkg::mul_req_t     mul_req,
	input  xrs_pkg::mul_rsp_t     mul_rsp,
	output logic                  empty,
	input  logic                  pop,
	output logic [63:0]           raw_word,
	output logic signed [31:0]    int_value,
	output logic [52:0]           fraction
);
	import xrs_pkg::*;

	back_state_t  st_q;
	back_state_t  st_d;
	xrs_item_t    cur_q;
	logic [63:0]  state_low_q;
	logic [63:0]  state_high_q;
	logic [63:0]  a5_q;
	logic [63:0]  word_q;
	logic [31:0]  ival_q;
	logic [63:0]  acc_q;
	logic [63:0]  first_q;
	logic         round_q;
	logic         res_valid_q;
	logic [63:0]  res_raw_q;
	logic [31:0]  res_int_q;
	logic [52:0]  res_frac_q;
	logic         load_res;
	logic         is_draw;
	logic [63:0]  mix_b;
	logic [63:0]  rot_w;
	logic [63:0]  xb;
	logic         slot_free;

	assign slot_free = !res_valid_q || pop;
	assign is_draw   = item.cmd inside {CMD_INT, CMD_FRAC};
	assign mix_b     = mul_rsp.product ^ (mul_rsp.product >> 31);
	assign rot_w     = rotl64(a5_q, 7);
	assign xb        = state_high_q ^ state_low_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (item_valid) begin
					case (item.cmd)
						CMD_SEED:          st_d = ST_SEED_IDX;
						CMD_INT, CMD_FRAC: st_d = ST_WORD;
						default:           st_d = ST_EMIT;
					endcase
				end
			end
			ST_WORD:     st_d = (cur_q.cmd == CMD_INT) ? ST_SCALE_GO : ST_EMIT;
			ST_SCALE_GO: st_d = ST_SCALE;
			ST_SCALE:    if (mul_rsp.done) st_d = ST_EMIT;
			ST_SEED_IDX: if (mul_rsp.done) st_d = ST_MIX0;
			ST_MIX0:     st_d = ST_MIX_A;
			ST_MIX_A:    if (mul_rsp.done) st_d = ST_MIX_B;
			ST_MIX_B:    if (mul_rsp.done) st_d = round_q ? ST_EMIT : ST_MIX0;
			ST_EMIT:     if (slot_free) st_d = ST_IDLE;
			default:     st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		take     = 1'b0;
		load_res = 1'b0;
		mul_req  = '0;
		case (st_q)
			ST_IDLE: begin
				take = item_valid;
				if (item_valid && item.cmd == CMD_SEED) begin
					mul_req.start = 1'b1;
					mul_req.a     = GOLDEN_GAMMA;
					mul_req.b     = {32'd0, item.idx1};
				end
			end
			ST_SCALE_GO: begin
				mul_req.start = 1'b1;
				mul_req.a     = {32'd0, word_q[63:32]};
				mul_req.b     = {32'd0, cur_q.width};
			end
			ST_MIX0: begin
				mul_req.start = 1'b1;
				mul_req.a     = acc_q ^ (acc_q >> 30);
				mul_req.b     = MIX_MUL_A;
			end
			ST_MIX_A: begin
				if (mul_rsp.done) begin
					mul_req.start = 1'b1;
					mul_req.a     = mul_rsp.product ^ (mul_rsp.product >> 27);
					mul_req.b     = MIX_MUL_B;
				end
			end
			ST_EMIT: load_res = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= item;
			a5_q  <= state_low_q + (state_low_q << 2);
		end
		if (st_q == ST_WORD) begin
			word_q <= rot_w + (rot_w << 3);
		end
		if (st_q == ST_SCALE && mul_rsp.done) begin
			ival_q <= cur_q.lo + mul_rsp.product[63:32];
		end
		if (st_q == ST_SEED_IDX && mul_rsp.done) begin
			acc_q <= (cur_q.seed ^ mul_rsp.product) + GOLDEN_GAMMA;
		end
		if (st_q == ST_MIX_B && mul_rsp.done && !round_q) begin
			first_q <= mix_b;
			acc_q   <= acc_q + GOLDEN_GAMMA;
		end
		if (load_res) begin
			res_raw_q  <= (cur_q.cmd inside {CMD_INT, CMD_FRAC}) ? word_q : '0;
			res_int_q  <= (cur_q.cmd == CMD_INT) ? ival_q : '0;
			res_frac_q <= (cur_q.cmd == CMD_FRAC) ? word_q[63:11] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			state_low_q  <= 64'd0;
			state_high_q <= 64'd1;
			round_q      <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (take) begin
				round_q <= 1'b0;
				if (is_draw) begin
					state_low_q  <= rotl64(state_low_q, 24) ^ xb ^ (xb << 16);
					state_high_q <= rotl64(xb, 37);
				end
			end
			if (st_q == ST_MIX_B && mul_rsp.done) begin
				if (!round_q) begin
					round_q <= 1'b1;
				end else begin
					state_low_q  <= first_q;
					state_high_q <= (first_q == '0 && mix_b == '0) ? 64'd1 : mix_b;
				end
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign empty     = !res_valid_q;
	assign raw_word  = res_raw_q;
	assign int_value = res_int_q;
	assign fraction  = res_frac_q;

	a_state_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_low_q != '0 || state_high_q != '0)
		else $error("generator state became all zero");

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (st_q == ST_SEED_IDX || st_q == ST_MIX_A ||
			st_q == ST_MIX_B || st_q == ST_SCALE))
		else $error("multiplier finished while the sequencer was not waiting");

	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> st_q != ST_IDLE)
		else $error("sequencer stayed idle after taking an item");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !pop |=> res_valid_q && $stable(res_raw_q))
		else $error("waiting result was overwritten or dropped");

endmodule

>>> rtl/xoroshiro_random_stream.sv
// Top level of the xoroshiro128** random stream block.
// Depends on xrs_pkg, xrs_front, xrs_mul64 and xrs_back.

// The block keeps one 128-bit xoroshiro128** state (reset to low word zero,
// high word one) and works as a queue on both sides: write a command with
// push while full is low, and read its single result while empty is low,
// taking it with pop. Command 0 seeds the state from seed_value and
// stream_index plus one through two splitmix64 steps and returns all-zero
// fields; command 1 advances the state and returns the raw word and an
// integer in [range_low, range_high] (bounds swapped if reversed, full span
// returns range_low); command 2 advances the state and returns the raw word
// and its top 53 bits as a 0.53 fraction; command 3 returns zeros and leaves
// the state alone. Commands are handled one at a time in order. The integer
// draw and the seed use the single shared 32x32 multiplier, which builds
// each 64-bit product from partial products in turn (one product for the
// integer scaling, five for a seed). A two-entry queue in front of the
// sequencer takes new commands while a result waits to be read. A finished
// command holds the sequencer, and the commands behind it, until the result
// register is free, which is at the latest the cycle the previous result is
// taken with pop.
module xoroshiro_random_stream (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          command,
	input  logic [63:0]         seed_value,
	input  logic [30:0]         stream_index,
	input  logic signed [31:0]  range_low,
	input  logic signed [31:0]  range_high,
	output logic                empty,
	input  logic                pop,
	output logic [63:0]         raw_word,
	output logic signed [31:0]  int_value,
	output logic [52:0]         fraction
);
	import xrs_pkg::*;

	// Classified commands travel from the front queue to the sequencer.
	xrs_item_t  item;
	logic       item_valid;
	logic       take;

	// Requests and products of the shared multiplier.
	mul_req_t   mul_req;
	mul_rsp_t   mul_rsp;

	xrs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.seed_value   (seed_value),
		.stream_index (stream_index),
		.range_low    (range_low),
		.range_high   (range_high),
		.item         (item),
		.item_valid   (item_valid),
		.take         (take)
	);

	xrs_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// The sequencer owns the generator state and the result register, so a
	// finished transfer waits there without blocking the front queue.
	xrs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.take       (take),
		.mul_req    (mul_req),
		.mul_rsp    (mul_rsp),
		.empty      (empty),
		.pop        (pop),
		.raw_word   (raw_word),
		.int_value  (int_value),
		.fraction   (fraction)
	);

endmodule
